[rtl/descending_priority_queue_assert.svh]
// Assertion macros shared by the priority queue RTL.
`ifndef DESCENDING_PRIORITY_QUEUE_ASSERT_SVH
`define DESCENDING_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define DPQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority queue assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define DPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority queue assertion failed");

`endif

[rtl/dpq_pkg.sv]
// Shared types and status codes of the descending priority queue.
package dpq_pkg;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // One stored queue entry.
  typedef struct packed {
    logic [31:0] pri;
    logic [31:0] val;
  } entry_t;

endpackage

[rtl/dpq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module dpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/descending_priority_queue.sv]
// Descending priority queue: entries kept sorted in a circular RAM buffer.
// A delete reads the head and reports from S_RDHEAD; an insert into an empty or
// full queue, or a delete on empty, is answered from idle; other inserts scan.
// Throughput is set by the single RAM read port: one entry moves per cycle.
// The result strobe fires once per request; the receiver cannot stall it.
// Reset empties the queue at once; no clearing pass over the RAM is needed.
module descending_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] priority_req_i,
  output logic               strobe_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_value_o,
  output logic signed [31:0] removed_priority_o,
  output logic [4:0]         occupancy_o
);

  import dpq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CapW = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RDHEAD = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_PLACE  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] k_q, k_d;
  entry_t        new_q, new_d;
  logic          strobe_q, strobe_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   rem_val_q, rem_val_d;
  logic [31:0]   rem_pri_q, rem_pri_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  // Logical slot offset from the head, wrapped into the circular buffer.
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CapW) begin
      s = s - CapW;
    end
    return s[IW-1:0];
  endfunction

  dpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request sequencer. An insert scans from the tail toward the head, moving
  // each lower-priority entry up one slot. During the scan the read trails the write by
  // two slots, so no scan read touches an entry that is being written.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    k_d       = k_q;
    new_d     = new_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    rem_val_d = rem_val_q;
    rem_pri_d = rem_pri_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = new_q;
    ram_raddr = head_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          new_d.pri = priority_req_i;
          new_d.val = value_i;
          rem_val_d = '0;
          rem_pri_d = '0;
          if (action_i) begin
            if (count_q == '0) begin
              strobe_d = 1'b1;
              status_d = ST_EMPTY;
            end else begin
              state_d = S_RDHEAD;
            end
          end else if (count_q == CapC) begin
            strobe_d = 1'b1;
            status_d = ST_FULL;
          end else if (count_q == '0) begin
            ram_we        = 1'b1;
            ram_wdata.pri = priority_req_i;
            ram_wdata.val = value_i;
            count_d       = count_q + CW'(1);
            strobe_d      = 1'b1;
            status_d      = ST_INSERTED;
          end else begin
            k_d       = IW'(count_q);
            ram_raddr = wrap_add(head_q, k_d - IW'(1));
            state_d   = S_SCAN;
          end
        end
      end

      S_RDHEAD: begin
        rem_val_d = ram_rdata.val;
        rem_pri_d = ram_rdata.pri;
        head_d    = wrap_add(head_q, IW'(1));
        count_d   = count_q - CW'(1);
        strobe_d  = 1'b1;
        status_d  = ST_REMOVED;
        state_d   = S_IDLE;
      end

      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, k_q);
        if ($signed(ram_rdata.pri) >= $signed(new_q.pri)) begin
          ram_wdata = new_q;
          count_d   = count_q + CW'(1);
          strobe_d  = 1'b1;
          status_d  = ST_INSERTED;
          state_d   = S_IDLE;
        end else begin
          ram_wdata = ram_rdata;
          k_d       = k_q - IW'(1);
          ram_raddr = wrap_add(head_q, k_q - IW'(2));
          if (k_q == IW'(1)) begin
            state_d = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = head_q;
        ram_wdata = new_q;
        count_d   = count_q + CW'(1);
        strobe_d  = 1'b1;
        status_d  = ST_INSERTED;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      k_q      <= '0;
      strobe_q <= 1'b0;
      status_q <= ST_INSERTED;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    new_q     <= new_d;
    rem_val_q <= rem_val_d;
    rem_pri_q <= rem_pri_d;
  end

  // Outputs.
  assign busy               = (state_q != S_IDLE);
  assign strobe_o           = strobe_q;
  assign status_o           = status_q;
  assign removed_value_o    = rem_val_q;
  assign removed_priority_o = rem_pri_q;
  assign occupancy_o        = 5'(count_q);

  `include "descending_priority_queue_assert.svh"

  `DPQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CapC)
  `DPQ_ASSERT_IMPL(a_strobe_idle, strobe_q, state_q == S_IDLE)
  `DPQ_ASSERT_NEXT(a_delete_reads, start && !busy && action_i && (count_q != '0),
                   state_q == S_RDHEAD)
  `DPQ_ASSERT_IMPL(a_removed_count, strobe_q && (status_q == ST_REMOVED),
                   (count_q + CW'(1)) == $past(count_q))

endmodule
